// ----- src/partition_allocator_fit_policies_assert.svh -----
// assertion macros used by the partition allocator datapath
`ifndef PARTITION_ALLOCATOR_FIT_POLICIES_ASSERT_SVH
`define PARTITION_ALLOCATOR_FIT_POLICIES_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PAFP_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pafp assertion failed");
`define PAFP_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pafp assertion failed");
`else
`define PAFP_ASSERT_IMP(label, clk, rst, ante, cons)
`define PAFP_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- src/pafp_pkg.sv -----
// types and codes of the partition allocator
`timescale 1ns / 1ps
package pafp_pkg;
   // request functions
   localparam logic [1:0] FUNC_ALLOC    = 2'd0;
   localparam logic [1:0] FUNC_VALIDATE = 2'd1;
   localparam logic [1:0] FUNC_APPEND   = 2'd2;
   localparam logic [1:0] FUNC_REBUILD  = 2'd3;

   // result status
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_NOFIT = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;
   localparam logic [1:0] ST_MISS  = 2'd3;

   // scheme modes and fit policies
   localparam logic       FIJAS     = 1'b0;
   localparam logic       DINAMICAS = 1'b1;
   localparam logic [1:0] FIT_FIRST = 2'd0;
   localparam logic [1:0] FIT_BEST  = 2'd1;
   localparam logic [1:0] FIT_WORST = 2'd2;
   localparam logic [31:0] INT_MAX  = 32'h7fff_ffff;

   // register indexes
   localparam logic [1:0] CSR_SCHEME = 2'd0;
   localparam logic [1:0] CSR_POLICY = 2'd1;
   localparam logic [1:0] CSR_MEMSZ  = 2'd2;

   // read address select
   localparam logic [1:0] RD_IDX  = 2'd0;
   localparam logic [1:0] RD_LAST = 2'd1;
   localparam logic [1:0] RD_PREV = 2'd2;

   // write select
   localparam logic [2:0] WR_NONE    = 3'd0;
   localparam logic [2:0] WR_REBUILD = 3'd1;
   localparam logic [2:0] WR_APPEND  = 3'd2;
   localparam logic [2:0] WR_SHIFT   = 3'd3;
   localparam logic [2:0] WR_REMAIN  = 3'd4;
   localparam logic [2:0] WR_OWNED   = 3'd5;

   // count update select
   localparam logic [1:0] CNT_HOLD    = 2'd0;
   localparam logic [1:0] CNT_REBUILD = 2'd1;
   localparam logic [1:0] CNT_INC     = 2'd2;

   // result select
   localparam logic [2:0] RES_NONE   = 3'd0;
   localparam logic [2:0] RES_OK     = 3'd1;
   localparam logic [2:0] RES_APPEND = 3'd2;
   localparam logic [2:0] RES_HIT    = 3'd3;
   localparam logic [2:0] RES_MISS   = 3'd4;
   localparam logic [2:0] RES_NOFIT  = 3'd5;
   localparam logic [2:0] RES_FULL   = 3'd6;
   localparam logic [2:0] RES_GRANT  = 3'd7;

   typedef struct packed {
      logic [1:0]  func;
      logic [15:0] owner_id;
      logic [16:0] request_size;
      logic [15:0] phys_address;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] granted_base;
      logic [3:0]  entry_index;
   } rsp_type;

   typedef struct packed {
      logic       load;
      logic       clr_scan;
      logic       rd_en;
      logic [1:0] rd_sel;
      logic       eval;
      logic       idx_inc;
      logic       idx_dec;
      logic       idx_load_count;
      logic [2:0] wr_sel;
      logic [1:0] cnt_sel;
      logic [2:0] res_sel;
      logic       rsp_load;
   } cmd_type;

   typedef struct packed {
      logic [1:0] func;
      logic       full;
      logic       count_zero;
      logic       scan_end;
      logic       vhit;
      logic       ffit;
      logic       pick_ok;
      logic       split;
      logic       shift_more;
   } stat_type;
endpackage

// ----- src/pafp_dpath.sv -----
// partition table memory, scan and split datapath
`timescale 1ns / 1ps
`include "partition_allocator_fit_policies_assert.svh"
module pafp_dpath #(
   parameter int MAX_PARTITIONS = 16,
   parameter int ADDR_BITS      = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  pafp_pkg::req_type req_data,
   input  logic              csr_valid,
   input  logic [1:0]        csr_index,
   input  logic [16:0]       csr_data,
   input  pafp_pkg::cmd_type cmd,
   output pafp_pkg::stat_type stat,
   output pafp_pkg::rsp_type rsp_data
);
   import pafp_pkg::*;

   localparam int VW = ADDR_BITS + 1;
   localparam int CW = (VW > 17) ? VW : 17;
   localparam int IW = $clog2(MAX_PARTITIONS);
   localparam int NW = $clog2(MAX_PARTITIONS + 1);
   localparam logic [CW:0] TOP = (CW + 1)'(1) << ADDR_BITS;

   // table memory
   logic [VW-1:0] mem_base  [MAX_PARTITIONS];
   logic [VW-1:0] mem_limit [MAX_PARTITIONS];
   logic          mem_free  [MAX_PARTITIONS];
   logic [15:0]   mem_owner [MAX_PARTITIONS];

   logic          mode_ff;
   logic [1:0]    policy_ff;
   logic [16:0]   msize_ff;
   req_type       req_ff;
   logic [NW-1:0] count_ff, count_in;
   logic [NW-1:0] idx_ff, idx_in;
   logic [IW-1:0] pick_ff;
   logic          pick_ok_ff;
   logic [VW-1:0] pick_size_ff, pk_base_ff, pk_limit_ff;
   logic [VW-1:0] rd_base_ff, rd_limit_ff;
   logic          rd_free_ff;
   logic [15:0]   rd_owner_ff;
   rsp_type       res_ff, res_in, rsp_ff;

   logic [IW-1:0] rd_addr, wr_addr;
   logic          wr_en, wr_free;
   logic [VW-1:0] wr_base, wr_limit;
   logic [15:0]   wr_owner;
   logic [VW-1:0] sz, cut, start;
   logic [CW:0]   app_sum, app_lim, reb_lim;
   logic          fits, upd, vhit;
   logic [CW-1:0] addr_x, need_x;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= DINAMICAS;
         policy_ff <= FIT_FIRST;
         msize_ff  <= 17'd4096;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_SCHEME: mode_ff   <= csr_data[0];
            CSR_POLICY: policy_ff <= csr_data[1:0];
            CSR_MEMSZ:  msize_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.load) req_ff <= req_data;
   end

   // entry evaluation on the read beat
   always_comb begin
      sz     = rd_limit_ff - rd_base_ff;
      addr_x = CW'(req_ff.phys_address);
      need_x = CW'(req_ff.request_size);
      fits   = rd_free_ff && (CW'(sz) >= need_x);
      vhit   = (addr_x >= CW'(rd_base_ff)) && (addr_x < CW'(rd_limit_ff));
      case (policy_ff)
         FIT_BEST:  upd = fits && (!pick_ok_ff || sz < pick_size_ff);
         FIT_WORST: upd = fits && (!pick_ok_ff || sz > pick_size_ff);
         default:   upd = fits && !pick_ok_ff;
      endcase
      cut     = VW'((CW + 1)'(pk_base_ff) + (CW + 1)'(req_ff.request_size));
      start   = (count_ff == '0) ? '0 : rd_limit_ff;
      app_sum = (CW + 1)'(start) + (CW + 1)'(req_ff.request_size);
      app_lim = (app_sum > TOP) ? TOP : app_sum;
      reb_lim = ((CW + 1)'(msize_ff) > TOP) ? TOP : (CW + 1)'(msize_ff);
   end

   // status toward the controller
   always_comb begin
      stat.func       = req_ff.func;
      stat.full       = count_ff >= NW'(MAX_PARTITIONS);
      stat.count_zero = count_ff == '0;
      stat.scan_end   = idx_ff == count_ff;
      stat.vhit       = vhit;
      stat.ffit       = fits && (policy_ff != FIT_BEST) && (policy_ff != FIT_WORST);
      stat.pick_ok    = pick_ok_ff;
      stat.split      = (mode_ff == DINAMICAS) && (cut != pk_limit_ff);
      stat.shift_more = (NW + 1)'(idx_ff) > ((NW + 1)'(pick_ff) + (NW + 1)'(1));
   end

   // read address
   always_comb begin
      case (cmd.rd_sel)
         RD_LAST: rd_addr = IW'(count_ff - NW'(1));
         RD_PREV: rd_addr = IW'(idx_ff - NW'(1));
         default: rd_addr = idx_ff[IW-1:0];
      endcase
   end

   // write port
   always_comb begin
      wr_en    = 1'b1;
      wr_addr  = pick_ff;
      wr_base  = pk_base_ff;
      wr_limit = pk_limit_ff;
      wr_free  = 1'b1;
      wr_owner = 16'd0;
      case (cmd.wr_sel)
         WR_REBUILD: begin
            wr_en    = mode_ff;
            wr_addr  = '0;
            wr_base  = '0;
            wr_limit = VW'(reb_lim);
         end
         WR_APPEND: begin
            wr_addr  = count_ff[IW-1:0];
            wr_base  = start;
            wr_limit = VW'(app_lim);
         end
         WR_SHIFT: begin
            wr_addr  = idx_ff[IW-1:0];
            wr_base  = rd_base_ff;
            wr_limit = rd_limit_ff;
            wr_free  = rd_free_ff;
            wr_owner = rd_owner_ff;
         end
         WR_REMAIN: begin
            wr_addr  = pick_ff + IW'(1);
            wr_base  = cut;
            wr_limit = pk_limit_ff;
         end
         WR_OWNED: begin
            wr_limit = (mode_ff == DINAMICAS) ? cut : pk_limit_ff;
            wr_free  = 1'b0;
            wr_owner = req_ff.owner_id;
         end
         default: wr_en = 1'b0;
      endcase
   end

   // memory write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_base[wr_addr]  <= wr_base;
         mem_limit[wr_addr] <= wr_limit;
         mem_free[wr_addr]  <= wr_free;
         mem_owner[wr_addr] <= wr_owner;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_base_ff  <= mem_base[rd_addr];
         rd_limit_ff <= mem_limit[rd_addr];
         rd_free_ff  <= mem_free[rd_addr];
         rd_owner_ff <= mem_owner[rd_addr];
      end
   end

   // entry count and scan index
   always_comb begin
      case (cmd.cnt_sel)
         CNT_REBUILD: count_in = (mode_ff == DINAMICAS) ? NW'(1) : '0;
         CNT_INC:     count_in = count_ff + NW'(1);
         default:     count_in = count_ff;
      endcase
      idx_in = idx_ff;
      if (cmd.clr_scan) idx_in = '0;
      else if (cmd.idx_load_count) idx_in = count_ff;
      else if (cmd.idx_inc) idx_in = idx_ff + NW'(1);
      else if (cmd.idx_dec) idx_in = idx_ff - NW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         idx_ff     <= '0;
         pick_ok_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         idx_ff   <= idx_in;
         if (cmd.clr_scan) pick_ok_ff <= 1'b0;
         else if (cmd.eval && upd) pick_ok_ff <= 1'b1;
      end
   end

   // chosen entry
   always_ff @(posedge clock) begin
      if (cmd.eval && upd) begin
         pick_ff      <= idx_ff[IW-1:0];
         pick_size_ff <= sz;
         pk_base_ff   <= rd_base_ff;
         pk_limit_ff  <= rd_limit_ff;
      end
   end

   // pending result
   always_comb begin
      res_in = res_ff;
      case (cmd.res_sel)
         RES_OK:     res_in = '{ST_OK, 16'd0, 4'd0};
         RES_APPEND: res_in = '{ST_OK, 16'd0, 4'((CW)'(count_ff))};
         RES_HIT:    res_in = '{ST_OK, 16'd0, 4'((CW)'(idx_ff))};
         RES_MISS:   res_in = '{ST_MISS, 16'd0, 4'd0};
         RES_NOFIT:  res_in = '{ST_NOFIT, 16'd0, 4'd0};
         RES_FULL:   res_in = '{ST_FULL, 16'd0, 4'd0};
         RES_GRANT:  res_in = '{ST_OK, 16'((CW)'(pk_base_ff)), 4'((CW)'(pick_ff))};
         default:    res_in = res_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
      if (cmd.rsp_load) rsp_ff <= res_ff;
   end

   assign rsp_data = rsp_ff;

   `PAFP_ASSERT_IMP(a_inc_room, clock, reset, cmd.cnt_sel == CNT_INC, !stat.full)
   `PAFP_ASSERT_IMP(a_shift_range, clock, reset, cmd.wr_sel == WR_SHIFT, stat.shift_more)
   `PAFP_ASSERT_IMP(a_grant_pick, clock, reset, cmd.res_sel == RES_GRANT, pick_ok_ff)
endmodule

// ----- src/pafp_ctrl.sv -----
// sequencer for the partition allocator
`timescale 1ns / 1ps
module pafp_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   input  pafp_pkg::stat_type stat,
   output pafp_pkg::cmd_type  cmd
);
   import pafp_pkg::*;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_DECODE   = 4'd1;
   localparam logic [3:0] S_APP_WAIT = 4'd2;
   localparam logic [3:0] S_SCAN_RD  = 4'd3;
   localparam logic [3:0] S_SCAN_EV  = 4'd4;
   localparam logic [3:0] S_ALLOC    = 4'd5;
   localparam logic [3:0] S_SHIFT_RD = 4'd6;
   localparam logic [3:0] S_SHIFT_WR = 4'd7;
   localparam logic [3:0] S_OWN      = 4'd8;
   localparam logic [3:0] S_DONE     = 4'd9;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            case (stat.func)
               FUNC_REBUILD: begin
                  cmd.wr_sel  = WR_REBUILD;
                  cmd.cnt_sel = CNT_REBUILD;
                  cmd.res_sel = RES_OK;
                  state_in    = S_DONE;
               end
               FUNC_APPEND: begin
                  if (stat.full) begin
                     cmd.res_sel = RES_FULL;
                     state_in    = S_DONE;
                  end else if (stat.count_zero) begin
                     cmd.wr_sel  = WR_APPEND;
                     cmd.cnt_sel = CNT_INC;
                     cmd.res_sel = RES_APPEND;
                     state_in    = S_DONE;
                  end else begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = RD_LAST;
                     state_in   = S_APP_WAIT;
                  end
               end
               default: begin
                  cmd.clr_scan = 1'b1;
                  state_in     = S_SCAN_RD;
               end
            endcase
         end
         S_APP_WAIT: begin
            cmd.wr_sel  = WR_APPEND;
            cmd.cnt_sel = CNT_INC;
            cmd.res_sel = RES_APPEND;
            state_in    = S_DONE;
         end
         S_SCAN_RD: begin
            if (stat.scan_end) begin
               if (stat.func == FUNC_VALIDATE) begin
                  cmd.res_sel = RES_MISS;
                  state_in    = S_DONE;
               end else begin
                  state_in = S_ALLOC;
               end
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_IDX;
               state_in   = S_SCAN_EV;
            end
         end
         S_SCAN_EV: begin
            cmd.eval    = stat.func == FUNC_ALLOC;
            cmd.idx_inc = 1'b1;
            if (stat.func == FUNC_VALIDATE && stat.vhit) begin
               cmd.res_sel = RES_HIT;
               state_in    = S_DONE;
            end else if (stat.func == FUNC_ALLOC && stat.ffit) begin
               state_in = S_ALLOC;
            end else begin
               state_in = S_SCAN_RD;
            end
         end
         S_ALLOC: begin
            if (!stat.pick_ok) begin
               cmd.res_sel = RES_NOFIT;
               state_in    = S_DONE;
            end else if (stat.split && stat.full) begin
               cmd.res_sel = RES_FULL;
               state_in    = S_DONE;
            end else if (stat.split) begin
               cmd.idx_load_count = 1'b1;
               state_in           = S_SHIFT_RD;
            end else begin
               cmd.wr_sel  = WR_OWNED;
               cmd.res_sel = RES_GRANT;
               state_in    = S_DONE;
            end
         end
         S_SHIFT_RD: begin
            if (stat.shift_more) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_PREV;
               state_in   = S_SHIFT_WR;
            end else begin
               cmd.wr_sel  = WR_REMAIN;
               cmd.cnt_sel = CNT_INC;
               state_in    = S_OWN;
            end
         end
         S_SHIFT_WR: begin
            cmd.wr_sel  = WR_SHIFT;
            cmd.idx_dec = 1'b1;
            state_in    = S_SHIFT_RD;
         end
         S_OWN: begin
            cmd.wr_sel  = WR_OWNED;
            cmd.res_sel = RES_GRANT;
            state_in    = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // output beat valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;
endmodule

// ----- src/partition_allocator_fit_policies.sv -----
// partition allocator top level: sequencer plus table datapath
//  channel | dir | handshake          | beat
//  req     | in  | req_valid/stall    | pafp_pkg::req_type
//  rsp     | out | rsp_valid/stall    | pafp_pkg::rsp_type
//  csr     | in  | csr_valid/ready    | csr_index, csr_data
// one request at a time; rebuild and full append go from decode to done
// validate and allocate read, then evaluate each entry over the single
// memory read port; a dynamic split reads and rewrites each moved entry
// one result register lets a new request enter while a result is stalled
// synchronous reset empties the table; entries read only below the count
`timescale 1ns / 1ps
module partition_allocator_fit_policies #(
   parameter int MAX_PARTITIONS = 16,
   parameter int ADDR_BITS      = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  pafp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output pafp_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [16:0]       csr_data
);
   import pafp_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   assign csr_ready = 1'b1;

   // controller
   pafp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath
   pafp_dpath #(
      .MAX_PARTITIONS (MAX_PARTITIONS),
      .ADDR_BITS      (ADDR_BITS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_data  (rsp_data)
   );
endmodule

// ----- dv/partition_allocator_fit_policies_checker.sv -----
// checker of the partition allocator: table predictor and result scoreboard
`timescale 1ns / 1ps
module partition_allocator_fit_policies_checker
   import pafp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   input  logic    csr_valid,
   input  logic    csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [16:0] csr_data,
   output int      fail_count,
   output int      pending
);
   localparam int NPART = 16;
   localparam logic [17:0] TOP = 18'h10000;

   // predicted table and registers
   logic [17:0] tbl_base [NPART];
   logic [17:0] tbl_limit [NPART];
   logic        tbl_free [NPART];
   logic [15:0] tbl_owner [NPART];
   int          tbl_count;
   logic        mode_q;
   logic [1:0]  policy_q;
   logic [16:0] memsz_q;
   rsp_type     expected_rsp [$];

   function automatic logic [17:0] clamp_top(logic [17:0] v);
      return (v > TOP) ? TOP : v;
   endfunction

   // pick a free entry by the current policy, -1 when none fits
   function automatic int pick_entry(logic [17:0] need);
      int pick;
      logic [17:0] psz, sz;
      pick = -1;
      psz = '0;
      for (int i = 0; i < tbl_count; i++) begin
         sz = tbl_limit[i] - tbl_base[i];
         if (!tbl_free[i] || sz < need) continue;
         if (policy_q == FIT_BEST) begin
            if (pick < 0 || sz < psz) begin pick = i; psz = sz; end
         end else if (policy_q == FIT_WORST) begin
            if (pick < 0 || sz > psz) begin pick = i; psz = sz; end
         end else begin
            return i;
         end
      end
      return pick;
   endfunction

   // apply one request to the predicted table
   function automatic rsp_type serve_request(req_type r);
      rsp_type o;
      int k;
      logic [17:0] cut, old_lim, start;
      o = '0;
      case (r.func)
         FUNC_ALLOC: begin
            k = pick_entry({1'b0, r.request_size});
            if (k < 0) o.status = ST_NOFIT;
            else begin
               old_lim = tbl_limit[k];
               cut = tbl_base[k] + r.request_size;
               if (mode_q != FIJAS && cut != old_lim && tbl_count >= NPART)
                  o.status = ST_FULL;
               else begin
                  if (mode_q != FIJAS && cut != old_lim) begin
                     for (int j = tbl_count; j > k + 1; j--) begin
                        tbl_base[j] = tbl_base[j-1];
                        tbl_limit[j] = tbl_limit[j-1];
                        tbl_free[j] = tbl_free[j-1];
                        tbl_owner[j] = tbl_owner[j-1];
                     end
                     tbl_base[k+1] = cut;
                     tbl_limit[k+1] = old_lim;
                     tbl_free[k+1] = 1'b1;
                     tbl_owner[k+1] = '0;
                     tbl_count++;
                     tbl_limit[k] = cut;
                  end
                  tbl_free[k] = 1'b0;
                  tbl_owner[k] = r.owner_id;
                  o.status = ST_OK;
                  o.granted_base = tbl_base[k][15:0];
                  o.entry_index = k[3:0];
               end
            end
         end
         FUNC_VALIDATE: begin
            o.status = ST_MISS;
            for (int i = 0; i < tbl_count; i++)
               if (r.phys_address >= tbl_base[i] && r.phys_address < tbl_limit[i]) begin
                  o.status = ST_OK;
                  o.entry_index = i[3:0];
                  break;
               end
         end
         FUNC_APPEND: begin
            if (tbl_count >= NPART) o.status = ST_FULL;
            else begin
               start = (tbl_count == 0) ? '0 : tbl_limit[tbl_count-1];
               tbl_base[tbl_count] = start;
               tbl_limit[tbl_count] = clamp_top(start + r.request_size);
               tbl_free[tbl_count] = 1'b1;
               tbl_owner[tbl_count] = '0;
               o.entry_index = tbl_count[3:0];
               tbl_count++;
            end
         end
         default: begin
            tbl_count = 0;
            if (mode_q != FIJAS) begin
               tbl_base[0] = '0;
               tbl_limit[0] = clamp_top({1'b0, memsz_q});
               tbl_free[0] = 1'b1;
               tbl_owner[0] = '0;
               tbl_count = 1;
            end
         end
      endcase
      return o;
   endfunction

   // watch the channels at each edge
   always @(posedge clock) begin
      rsp_type exp_r;
      if (reset) begin
         tbl_count = 0;
         mode_q = DINAMICAS;
         policy_q = FIT_FIRST;
         memsz_q = 17'd4096;
         expected_rsp.delete();
         fail_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_SCHEME) mode_q = csr_data[0];
            else if (csr_index == CSR_POLICY) policy_q = csr_data[1:0];
            else if (csr_index == CSR_MEMSZ) memsz_q = csr_data;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("unexpected result beat %h", rsp_data);
            end else begin
               exp_r = expected_rsp.pop_front();
               if (exp_r.status !== rsp_data.status
                   || exp_r.granted_base !== rsp_data.granted_base
                   || exp_r.entry_index !== rsp_data.entry_index) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display(
                        "result mismatch: exp st %0d base %h idx %0d, got st %0d base %h idx %0d",
                        exp_r.status, exp_r.granted_base, exp_r.entry_index,
                        rsp_data.status, rsp_data.granted_base, rsp_data.entry_index);
               end
            end
         end
         if (req_valid && !req_stall) expected_rsp.push_back(serve_request(req_data));
      end
      pending = expected_rsp.size();
   end
endmodule

// ----- dv/partition_allocator_fit_policies_tb.sv -----
// testbench top of the partition allocator: stimulus and verdict
`timescale 1ns / 1ps
module partition_allocator_fit_policies_tb;
   import pafp_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = '0;
   logic [16:0] csr_data = '0;
   int fail_count, pending;
   int idle_cycles = 0;
   bit quiet_end = 1'b0;
   bit hold_off = 1'b0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   partition_allocator_fit_policies dut (
      .clock, .reset, .req_valid, .req_stall, .req_data, .rsp_valid, .rsp_stall,
      .rsp_data, .csr_valid, .csr_ready, .csr_index, .csr_data);

   partition_allocator_fit_policies_checker chk (
      .clock, .reset, .req_valid, .req_stall, .req_data, .rsp_valid, .rsp_stall,
      .rsp_data, .csr_valid, .csr_ready, .csr_index, .csr_data, .fail_count, .pending);

   // watchdog on cycles without any accepted beat
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // receiver stalls in random bursts, one long hold-off on request
   initial begin
      int n;
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_stall <= 1'b1;
            repeat (400) @(posedge clock);
            rsp_stall <= 1'b0;
            hold_off = 1'b0;
         end else if (!quiet_end && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 8);
            rsp_stall <= 1'b1;
            repeat (n - 1) @(posedge clock);
            @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // valid stays high into the next beat unless an idle burst comes first
   task automatic send_req(logic [1:0] f, logic [15:0] own, logic [16:0] sz,
                           logic [15:0] addr);
      req_type r;
      r.func = f;
      r.owner_id = own;
      r.request_size = sz;
      r.phys_address = addr;
      if (!quiet_end && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [16:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // random sizes, mostly small, sometimes extreme
   function automatic logic [16:0] rand_size();
      case ($urandom_range(0, 9))
         0: return 17'd0;
         1: return 17'h10000;
         2: return 17'($urandom_range(0, 17'h1ffff));
         default: return 17'($urandom_range(1, 600));
      endcase
   endfunction

   // one phase of well-formed traffic with noise mixed in
   task automatic run_phase(int n_items);
      int sel;
      for (int i = 0; i < n_items; i++) begin
         sel = $urandom_range(0, 19);
         if (sel == 0)
            send_req(FUNC_REBUILD, 16'($urandom), 17'($urandom), 16'($urandom));
         else if (sel < 6)
            send_req(FUNC_APPEND, 16'($urandom), rand_size(), 16'($urandom));
         else if (sel < 13)
            send_req(FUNC_ALLOC, 16'($urandom), rand_size(), 16'($urandom));
         else
            send_req(FUNC_VALIDATE, 16'($urandom), 17'($urandom),
                     ($urandom_range(0, 1)) ? 16'($urandom_range(0, 5000)) : 16'($urandom));
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset table, rebuild at reset size, splits and a no-fit request
      send_req(FUNC_VALIDATE, 16'h0, 17'h0, 16'h0);
      send_req(FUNC_ALLOC, 16'hffff, 17'd10, 16'h0);
      send_req(FUNC_REBUILD, 16'h0, 17'h0, 16'h0);
      send_req(FUNC_ALLOC, 16'hffff, 17'd100, 16'hffff);
      send_req(FUNC_ALLOC, 16'h1234, 17'd0, 16'h0);
      send_req(FUNC_ALLOC, 16'h0001, 17'h1ffff, 16'h0);
      send_req(FUNC_VALIDATE, 16'h0, 17'h0, 16'd99);
      send_req(FUNC_VALIDATE, 16'h0, 17'h0, 16'd4095);
      send_req(FUNC_VALIDATE, 16'h0, 17'h0, 16'hffff);
      drain_results();
      // fixed mode, appends to a full table, saturation at the top
      write_reg(CSR_SCHEME, 17'(FIJAS));
      write_reg(CSR_POLICY, 17'(FIT_BEST));
      write_reg(CSR_MEMSZ, 17'h1ffff);
      send_req(FUNC_REBUILD, 16'h0, 17'h0, 16'h0);
      for (int i = 0; i < 17; i++)
         send_req(FUNC_APPEND, 16'h0, (i == 15) ? 17'h1ffff : 17'(i % 3 * 50), 16'h0);
      send_req(FUNC_ALLOC, 16'haaaa, 17'd50, 16'h0);
      send_req(FUNC_VALIDATE, 16'h0, 17'h0, 16'hffff);
      drain_results();

      // random phases across register settings, extremes included
      for (int ph = 0; ph < 10; ph++) begin
         write_reg(CSR_SCHEME, 17'(ph % 2));
         write_reg(CSR_POLICY, 17'(ph % 4));
         write_reg(CSR_MEMSZ, (ph == 2) ? 17'd1 : (ph == 5) ? 17'h10000 :
                   (ph == 7) ? 17'h1ffff : 17'($urandom_range(1, 65536)));
         send_req(FUNC_REBUILD, 16'h0, 17'h0, 16'h0);
         if (ph == 3) hold_off = 1'b1;
         if (ph == 9) quiet_end = 1'b1;
         run_phase(100);
         // sender pauses until all results are in
         drain_results();
      end

      while (pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
